>>> rtl/lfsa_pkg.sv
// Package for the lattice fit score and assign block.
// Holds the item structs, controller states, command and status structs and constants.
// No dependencies.
`default_nettype none

package lfsa_pkg;

  // Field and register widths.
  localparam int unsigned COEF_W     = 21;
  localparam int unsigned ROW_W      = 3 * COEF_W;
  localparam int unsigned VEC_W      = 32;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned LABEL_W    = 16;
  localparam int unsigned OWN_W      = 15;
  localparam int unsigned FRAC_W     = 40;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  // One half in the fraction format of a matrix-vector product.
  localparam logic [FRAC_W-1:0] HALF_ONE = {1'b1, {(FRAC_W-1){1'b0}}};

  // Label that marks a released or unassigned item.
  localparam logic [LABEL_W-1:0] LABEL_NONE = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ROW0 = 3'd0,
    CFG_MATRIX_ROW1 = 3'd1,
    CFG_MATRIX_ROW2 = 3'd2,
    CFG_TOL_SQ      = 3'd3,
    CFG_OWN_LABEL   = 3'd4
  } cfg_reg_e;

  typedef logic [2:0][ROW_W-1:0] matrix_t;

  // Input item.
  typedef struct packed {
    logic signed [VEC_W-1:0]   vec_x;
    logic signed [VEC_W-1:0]   vec_y;
    logic signed [VEC_W-1:0]   vec_z;
    logic [ERR_W-1:0]          old_error;
    logic signed [LABEL_W-1:0] old_label;
    logic                      last_item;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [ERR_W-1:0]          new_error;
    logic signed [LABEL_W-1:0] new_label;
    logic                      claimed;
    logic [ERR_W-1:0]          claim_count;
    logic                      is_last;
  } out_item_t;

  // Operand selection of the shared three-multiplier unit.
  typedef enum logic [1:0] {
    MUL_ROW0   = 2'd0,
    MUL_ROW1   = 2'd1,
    MUL_ROW2   = 2'd2,
    MUL_SQUARE = 2'd3
  } mul_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_ROW0   = 3'd1,
    S_ROW1   = 3'd2,
    S_ROW2   = 3'd3,
    S_DIST   = 3'd4,
    S_SQUARE = 3'd5,
    S_FINISH = 3'd6
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        mul_en;
    mul_sel_e    mul_sel;
    logic        dist_en;
    logic [1:0]  dist_idx;
    logic        finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/lfsa_ctrl.sv
// Controller of the lattice fit score and assign block.
// Sequences the three matrix rows, the distance step and the squares; uses lfsa_pkg.
`default_nettype none

module lfsa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lfsa_pkg::dp_sts_t sts_i,
  output lfsa_pkg::dp_cmd_t    cmd_o
);

  lfsa_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfsa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lfsa_pkg::S_ROW0;
      end
      lfsa_pkg::S_ROW0:   state_d = lfsa_pkg::S_ROW1;
      lfsa_pkg::S_ROW1:   state_d = lfsa_pkg::S_ROW2;
      lfsa_pkg::S_ROW2:   state_d = lfsa_pkg::S_DIST;
      lfsa_pkg::S_DIST:   state_d = lfsa_pkg::S_SQUARE;
      lfsa_pkg::S_SQUARE: state_d = lfsa_pkg::S_FINISH;
      lfsa_pkg::S_FINISH: begin
        if (!sts_i.out_busy) state_d = lfsa_pkg::S_IDLE;
      end
      default: state_d = lfsa_pkg::S_IDLE;
    endcase
  end

  // Outputs: commands for each step.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = lfsa_pkg::MUL_ROW0;
    in_ready_o    = 1'b0;
    case (state_q)
      lfsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lfsa_pkg::S_ROW0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfsa_pkg::MUL_ROW0;
      end
      lfsa_pkg::S_ROW1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = lfsa_pkg::MUL_ROW1;
        cmd_o.dist_en  = 1'b1;
        cmd_o.dist_idx = 2'd0;
      end
      lfsa_pkg::S_ROW2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = lfsa_pkg::MUL_ROW2;
        cmd_o.dist_en  = 1'b1;
        cmd_o.dist_idx = 2'd1;
      end
      lfsa_pkg::S_DIST: begin
        cmd_o.dist_en  = 1'b1;
        cmd_o.dist_idx = 2'd2;
      end
      lfsa_pkg::S_SQUARE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfsa_pkg::MUL_SQUARE;
      end
      lfsa_pkg::S_FINISH: begin
        cmd_o.finish = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // An accepted item keeps the input closed until its result is written.
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input open right after an accepted item");

  // A result is only written into a free output slot.
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_busy)
    else $error("result written over a pending result");

  // The distance of the last row follows the last row's products.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfsa_pkg::S_ROW2 |=> cmd_o.dist_en && cmd_o.dist_idx == 2'd2)
    else $error("row sequence broken");

endmodule

`default_nettype wire

>>> rtl/lfsa_dp.sv
// Datapath of the lattice fit score and assign block: shared three-multiplier unit,
// distance step, error sum, claim decision, claim counter and output register. Uses lfsa_pkg.
`default_nettype none

module lfsa_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lfsa_pkg::dp_cmd_t             cmd_i,
  output lfsa_pkg::dp_sts_t                  sts_o,
  input  wire lfsa_pkg::in_item_t            in_data_i,
  input  wire lfsa_pkg::matrix_t             matrix_i,
  input  wire logic [lfsa_pkg::ERR_W-1:0]    tol_sq_i,
  input  wire logic [lfsa_pkg::OWN_W-1:0]    own_label_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lfsa_pkg::out_item_t                out_data_o
);

  lfsa_pkg::in_item_t                      item_q;
  logic [2:0][lfsa_pkg::PROD_W-1:0]        prod_q;
  logic [2:0][lfsa_pkg::DIST_W-1:0]        dist_q;
  logic signed [lfsa_pkg::MUL_W-1:0]       mul_a   [3];
  logic signed [lfsa_pkg::MUL_W-1:0]       mul_b   [3];
  logic signed [2*lfsa_pkg::MUL_W-1:0]     mul_p   [3];
  logic [lfsa_pkg::ROW_W-1:0]              row_sel;
  logic [lfsa_pkg::VEC_W-1:0]              vec     [3];
  logic [lfsa_pkg::FRAC_W-1:0]             frac;
  logic [lfsa_pkg::FRAC_W-1:0]             dist_full;
  logic [lfsa_pkg::PROD_W-1:0]             sq_sum;
  logic [lfsa_pkg::ERR_W-1:0]              err;
  logic                                    claim;
  logic [lfsa_pkg::LABEL_W-1:0]            own_ext;
  logic [lfsa_pkg::ERR_W-1:0]              count_q, count_next;
  lfsa_pkg::out_item_t                     out_q, out_d;
  logic                                    out_valid_q, out_valid_d;

  // Input item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // Operand selection: a matrix row against the vector, or each distance squared.
  always_comb begin
    vec[0] = item_q.vec_x;
    vec[1] = item_q.vec_y;
    vec[2] = item_q.vec_z;
    case (cmd_i.mul_sel)
      lfsa_pkg::MUL_ROW0: row_sel = matrix_i[0];
      lfsa_pkg::MUL_ROW1: row_sel = matrix_i[1];
      lfsa_pkg::MUL_ROW2: row_sel = matrix_i[2];
      default:            row_sel = matrix_i[0];
    endcase
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.mul_sel == lfsa_pkg::MUL_SQUARE) begin
        mul_a[c] = {1'b0, dist_q[c]};
        mul_b[c] = {1'b0, dist_q[c]};
      end else begin
        mul_a[c] = {{(lfsa_pkg::MUL_W - lfsa_pkg::COEF_W){row_sel[c*lfsa_pkg::COEF_W
                     + lfsa_pkg::COEF_W - 1]}}, row_sel[c*lfsa_pkg::COEF_W +: lfsa_pkg::COEF_W]};
        mul_b[c] = {vec[c][lfsa_pkg::VEC_W-1], vec[c]};
      end
      mul_p[c] = mul_a[c] * mul_b[c];
    end
  end

  // Product registers of the three multipliers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= mul_p[c][lfsa_pkg::PROD_W-1:0];
      end
    end
  end

  // Distance to the nearest integer of one row's sum, truncated to 32 fraction bits.
  always_comb begin
    frac = prod_q[0][lfsa_pkg::FRAC_W-1:0] + prod_q[1][lfsa_pkg::FRAC_W-1:0]
         + prod_q[2][lfsa_pkg::FRAC_W-1:0];
    dist_full = (frac > lfsa_pkg::HALF_ONE) ? (lfsa_pkg::FRAC_W'(0) - frac) : frac;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_en) dist_q[cmd_i.dist_idx] <= dist_full[lfsa_pkg::FRAC_W-1 -: lfsa_pkg::DIST_W];
  end

  // Error sum, claim decision and label update.
  always_comb begin
    sq_sum  = prod_q[0] + prod_q[1] + prod_q[2];
    err     = {1'b0, sq_sum[lfsa_pkg::PROD_W-1 -: lfsa_pkg::ERR_W-1]};
    claim   = (err < tol_sq_i) && (err < item_q.old_error);
    own_ext = {1'b0, own_label_i};
    count_next = (claim && (count_q != '1)) ? count_q + 1'b1 : count_q;
    out_d.new_error   = claim ? err : item_q.old_error;
    if (claim) begin
      out_d.new_label = own_ext;
    end else if (item_q.old_label == own_ext) begin
      out_d.new_label = lfsa_pkg::LABEL_NONE;
    end else begin
      out_d.new_label = item_q.old_label;
    end
    out_d.claimed     = claim;
    out_d.claim_count = count_next;
    out_d.is_last     = item_q.last_item;
    out_valid_d = cmd_i.finish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Claim counter of the current run and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.finish) count_q <= item_q.last_item ? '0 : count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // A claimed result always carries an error below the tolerance.
  a_claim_tol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !out_q.claimed || (out_q.new_error < $past(tol_sq_i)))
    else $error("claimed result above tolerance");

  // A written result is presented on the next cycle.
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("written result not presented");

  // The run count clears after the final item's result.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && item_q.last_item |=> count_q == '0)
    else $error("claim count kept past the final item");

endmodule

`default_nettype wire

>>> rtl/lattice_fit_score_assign.sv
// Lattice fit score and assign: the result of an item is presented after its finish step writes it.
// One item at a time: the shared three-multiplier unit makes three matrix-row passes and one
// squaring pass, with one distance step between the last row and the squares.
// A finished result waits in an output register; the next item is taken once it is written.
// Reset (rst_ni, asynchronous, active low) clears config, out_valid, claim count and controller.
`default_nettype none

module lattice_fit_score_assign (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lfsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lfsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lfsa_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lfsa_pkg::out_item_t                  out_data_o
);

  lfsa_pkg::matrix_t                matrix_q;
  logic [lfsa_pkg::ERR_W-1:0]       tol_sq_q;
  logic [lfsa_pkg::OWN_W-1:0]       own_label_q;
  lfsa_pkg::dp_cmd_t                cmd;
  lfsa_pkg::dp_sts_t                sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q    <= '0;
      tol_sq_q    <= '0;
      own_label_q <= '0;
    end else if (cfg_we_i) begin
      case (lfsa_pkg::cfg_reg_e'(cfg_idx_i))
        lfsa_pkg::CFG_MATRIX_ROW0: matrix_q[0] <= cfg_wdata_i;
        lfsa_pkg::CFG_MATRIX_ROW1: matrix_q[1] <= cfg_wdata_i;
        lfsa_pkg::CFG_MATRIX_ROW2: matrix_q[2] <= cfg_wdata_i;
        lfsa_pkg::CFG_TOL_SQ:      tol_sq_q    <= cfg_wdata_i[lfsa_pkg::ERR_W-1:0];
        lfsa_pkg::CFG_OWN_LABEL:   own_label_q <= cfg_wdata_i[lfsa_pkg::OWN_W-1:0];
        default: ;
      endcase
    end
  end

  // Step sequencer.
  lfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and result path.
  lfsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .matrix_i    (matrix_q),
    .tol_sq_i    (tol_sq_q),
    .own_label_i (own_label_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
